/* rtl/rcm_pkg.sv */
// Shared types and constants for the Roberts cross magnitude block.
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int MAX_ROWS    = 4096;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int PIX_W       = 8;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int ROWS_CFG_W  = 13;
    localparam int COLS_CFG_W  = 11;
    localparam int SUMSQ_W     = 17;
    localparam int RAD_W       = 18;
    localparam int ROOT_W      = 9;
    localparam int REM_W       = 12;
    localparam int SQRT_STEPS  = 9;
    localparam int STEP_W      = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W  = FIFO_PTR_W + 1;

    // last indexes after reset: 480 rows, 640 columns
    localparam logic [ROW_W-1:0] ROWS_LAST_RST = 12'd479;
    localparam logic [COL_W-1:0] COLS_LAST_RST = 10'd639;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'd1;

    typedef struct packed {
        logic [ROW_W-1:0]   out_row;
        logic [COL_W-1:0]   out_col;
        logic [SUMSQ_W-1:0] sumsq;
        logic               grad;
        logic               last;
    } rcm_job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CALC,
        BK_DONE
    } rcm_back_state_t;

endpackage

/* rtl/rcm_ram.sv */
// Generic single-clock RAM, one write port, one registered read port (read-first).
`timescale 1ns / 1ps

module rcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rcm_front.sv */
// Front end: config registers, position counters, line store and gradient sum of squares.
`timescale 1ns / 1ps

module rcm_front import rcm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [FIFO_LVL_W-1:0] fifo_level,
    output logic                  push,
    output rcm_job_t              push_job
);

    logic [ROW_W-1:0] rows_last_reg, rows_last_next;
    logic [COL_W-1:0] cols_last_reg, cols_last_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic             st_vld_reg;
    logic [PIX_W-1:0] st_px_reg;
    logic [ROW_W-1:0] st_orow_reg;
    logic [COL_W-1:0] st_ocol_reg;
    logic             st_grad_reg;
    logic             st_last_reg;

    logic [PIX_W-1:0] left_reg, upleft_reg;
    logic [PIX_W-1:0] above;

    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic             grad;
    logic             accept;

    logic [ROWS_CFG_W-1:0] rows_val;
    logic [COLS_CFG_W-1:0] cols_val;

    logic [PIX_W-1:0]     adx, ady;
    logic [2*PIX_W-1:0]   sqx, sqy;

    assign accept    = s_valid && s_ready;
    assign s_ready   = ({1'b0, fifo_level} + {{FIFO_LVL_W{1'b0}}, st_vld_reg})
                       < (FIFO_LVL_W+1)'(FIFO_DEPTH);
    assign cfg_ready = 1'b1;

    // store the clamped last index of each dimension
    always_comb begin
        rows_val       = cfg_data[ROWS_CFG_W-1:0];
        cols_val       = cfg_data[COLS_CFG_W-1:0];
        rows_last_next = rows_last_reg;
        cols_last_next = cols_last_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_IMAGE_ROWS: begin
                    if (rows_val == '0) begin
                        rows_last_next = '0;
                    end else if (rows_val > ROWS_CFG_W'(MAX_ROWS)) begin
                        rows_last_next = ROW_W'(MAX_ROWS - 1);
                    end else begin
                        rows_last_next = ROW_W'(rows_val - 1'b1);
                    end
                end
                REG_IMAGE_COLS: begin
                    if (cols_val == '0) begin
                        cols_last_next = '0;
                    end else if (cols_val > COLS_CFG_W'(MAX_COLS)) begin
                        cols_last_next = COL_W'(MAX_COLS - 1);
                    end else begin
                        cols_last_next = COL_W'(cols_val - 1'b1);
                    end
                end
                default: ;
            endcase
        end
    end

    // routing: row zero -> last-row zero, column zero -> last-column zero
    always_comb begin
        if (row_reg == '0) begin
            orow = rows_last_reg;
            ocol = col_reg;
            grad = 1'b0;
        end else if (col_reg == '0) begin
            orow = row_reg - 1'b1;
            ocol = cols_last_reg;
            grad = 1'b0;
        end else begin
            orow = row_reg - 1'b1;
            ocol = col_reg - 1'b1;
            grad = 1'b1;
        end
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept) begin
            if (col_reg >= cols_last_reg) begin
                col_next = '0;
                row_next = (row_reg >= rows_last_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    rcm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (s_pixel),
        .raddr (col_reg),
        .rdata (above)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_last_reg <= ROWS_LAST_RST;
            cols_last_reg <= COLS_LAST_RST;
            row_reg       <= '0;
            col_reg       <= '0;
            st_vld_reg    <= 1'b0;
            left_reg      <= '0;
            upleft_reg    <= '0;
        end else begin
            rows_last_reg <= rows_last_next;
            cols_last_reg <= cols_last_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            st_vld_reg    <= accept;
            if (st_vld_reg) begin
                upleft_reg <= above;
                left_reg   <= st_px_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_px_reg   <= s_pixel;
            st_orow_reg <= orow;
            st_ocol_reg <= ocol;
            st_grad_reg <= grad;
            st_last_reg <= (row_reg == rows_last_reg) && (col_reg == cols_last_reg);
        end
    end

    // line store data lands in the cycle after the accept
    assign adx = (upleft_reg >= st_px_reg) ? upleft_reg - st_px_reg : st_px_reg - upleft_reg;
    assign ady = (above >= left_reg) ? above - left_reg : left_reg - above;
    assign sqx = adx * adx;
    assign sqy = ady * ady;

    assign push             = st_vld_reg;
    assign push_job.out_row = st_orow_reg;
    assign push_job.out_col = st_ocol_reg;
    assign push_job.sumsq   = SUMSQ_W'(sqx) + SUMSQ_W'(sqy);
    assign push_job.grad    = st_grad_reg;
    assign push_job.last    = st_last_reg;

endmodule

/* rtl/rcm_fifo.sv */
// Small job queue between the front end and the square-root back end.
`timescale 1ns / 1ps

module rcm_fifo import rcm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rcm_job_t              push_job,
    input  logic                  pop,
    output rcm_job_t              head,
    output logic                  empty,
    output logic [FIFO_LVL_W-1:0] level
);

    rcm_job_t                entries [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [FIFO_LVL_W-1:0]   level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + 1'b1;
                2'b01:   level_reg <= level_reg - 1'b1;
                default: level_reg <= level_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wptr_reg] <= push_job;
        end
    end

    assign head  = entries[rptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

/* rtl/rcm_back.sv */
// Back end: bit-serial integer square root, saturation and output register.
`timescale 1ns / 1ps

module rcm_back import rcm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  rcm_job_t         head,
    input  logic             empty,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ROW_W-1:0] m_out_row,
    output logic [COL_W-1:0] m_out_col,
    output logic [PIX_W-1:0] m_magnitude,
    output logic             m_frame_end
);

    rcm_back_state_t state_reg, state_next;

    rcm_job_t          job_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;

    logic              m_valid_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [PIX_W-1:0]  m_mag_reg;
    logic              m_end_reg;

    logic              out_free;
    logic              calc_en;
    logic              load_out;
    logic              last_step;
    logic [REM_W-1:0]  rem_sh, trial;
    logic [PIX_W-1:0]  mag;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == STEP_W'(SQRT_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    state_next = head.grad ? BK_CALC : BK_DONE;
                end
            end
            BK_CALC: begin
                if (last_step) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        calc_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BK_IDLE: pop      = !empty;
            BK_CALC: calc_en  = 1'b1;
            BK_DONE: load_out = out_free;
            default: ;
        endcase
    end

    // one root bit per cycle, two radicand bits consumed each step
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign mag    = !job_reg.grad ? '0 :
                    (root_reg[ROOT_W-1] ? {PIX_W{1'b1}} : root_reg[PIX_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg  <= head;
            rad_reg  <= {1'b0, head.sumsq};
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= '0;
        end else if (calc_en) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            step_reg <= step_reg + 1'b1;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (load_out) begin
            m_row_reg <= job_reg.out_row;
            m_col_reg <= job_reg.out_col;
            m_mag_reg <= mag;
            m_end_reg <= job_reg.last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_magnitude = m_mag_reg;
    assign m_frame_end = m_end_reg;

endmodule

/* rtl/roberts_cross_magnitude.sv */
// Top level of the streaming Roberts cross gradient magnitude block.
// Pixels enter in raster order on s_valid/s_ready/s_pixel; each accepted word
// yields exactly one result word on m_valid/m_ready with its position
// (m_out_row, m_out_col), the saturated magnitude and m_frame_end on the
// result caused by the last pixel of a frame. Row-zero inputs return the
// last-row zeros, column-zero inputs the last-column zeros.
// image_rows (index 0) and image_cols (index 1) are written on the cfg port,
// which is always ready; write them only while the block is idle.
// Flow: an accepted pixel is registered in the front end and then pushed
// into the job queue; the back end pops a job, runs the bit-serial square
// root for a gradient result (one root bit per cycle) or goes straight to
// the output for a border result, and takes the next job only after loading
// the output register. The square-root unit sets the throughput.
// A 4-entry queue decouples the front end from the back end; s_ready drops
// when the queue would fill, and a stalled receiver holds the output register
// and, through the queue, the input. Reset clears counters, the queue and the
// output valid and restores 480 x 640; the line store needs no clearing.
`timescale 1ns / 1ps

module roberts_cross_magnitude import rcm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ROW_W-1:0]      m_out_row,
    output logic [COL_W-1:0]      m_out_col,
    output logic [PIX_W-1:0]      m_magnitude,
    output logic                  m_frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                  push;
    rcm_job_t              push_job;
    logic                  pop;
    rcm_job_t              head;
    logic                  empty;
    logic [FIFO_LVL_W-1:0] level;

    rcm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_level (level),
        .push       (push),
        .push_job   (push_job)
    );

    rcm_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .level    (level)
    );

    rcm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_magnitude (m_magnitude),
        .m_frame_end (m_frame_end)
    );

endmodule

/* tb/roberts_cross_magnitude_test.sv */
// Self-checking testbench for the streaming Roberts cross magnitude block.
`timescale 1ns / 1ps

module roberts_cross_magnitude_test;
    import rcm_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_PCT    = 29;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] mag;
        logic             fin;
    } gradient_word_t;

    typedef enum int {
        PX_NOISE,
        PX_BINARY,
        PX_FLAT,
        PX_STRIPES
    } pixel_style_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ROW_W-1:0]      m_out_row;
    logic [COL_W-1:0]      m_out_col;
    logic [PIX_W-1:0]      m_magnitude;
    logic                  m_frame_end;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow of the block: line store, neighbors, raster position, sizes
    bit [PIX_W-1:0] line_mem [MAX_COLS];
    bit [PIX_W-1:0] left_px = '0;
    bit [PIX_W-1:0] diag_px = '0;
    int             row_pos = 0;
    int             col_pos = 0;
    int             line_fill = 0;
    int             rows_reg = 480;
    int             cols_reg = 640;

    logic [PIX_W-1:0] pixel_backlog [$];
    gradient_word_t   gradient_words [$];
    int               items_queued = 0;
    int               items_taken = 0;
    int               mismatches = 0;
    int               quiet_cycles = 0;
    int               hold_asks = 0;
    int               hold_served = 0;
    int               hold_left = 0;
    bit               calm = 1'b0;

    roberts_cross_magnitude dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_magnitude (m_magnitude),
        .m_frame_end (m_frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic int clamp_count(input int v, input int hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int sat_root(input int sumsq);
        int r;
        r = 0;
        while (r < 255 && (r + 1) * (r + 1) <= sumsq)
            r++;
        return r;
    endfunction

    // advance the shadow by one pixel and queue the word it must produce
    task automatic roberts_advance(input logic [PIX_W-1:0] px);
        int             rows_eff;
        int             cols_eff;
        int             slot;
        int             gx;
        int             gy;
        bit [PIX_W-1:0] above;
        gradient_word_t w;
        rows_eff = clamp_count(rows_reg, MAX_ROWS);
        cols_eff = clamp_count(cols_reg, MAX_COLS);
        slot = (col_pos < MAX_COLS) ? col_pos : 0;
        above = line_mem[slot];
        w.fin = (row_pos == rows_eff - 1) && (col_pos == cols_eff - 1);
        w.mag = '0;
        if (row_pos == 0) begin
            w.row = ROW_W'(rows_eff - 1);
            w.col = COL_W'(col_pos);
        end else if (col_pos == 0) begin
            w.row = ROW_W'(row_pos - 1);
            w.col = COL_W'(cols_eff - 1);
        end else begin
            gx = int'(diag_px) - int'(px);
            gy = int'(above) - int'(left_px);
            w.mag = PIX_W'(sat_root(gx * gx + gy * gy));
            w.row = ROW_W'(row_pos - 1);
            w.col = COL_W'(col_pos - 1);
        end
        diag_px = above;
        left_px = px;
        line_mem[slot] = px;
        if (slot >= line_fill)
            line_fill = slot + 1;
        if (col_pos >= cols_eff - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= rows_eff - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        gradient_words.push_back(w);
    endtask

    task automatic flag_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IMAGE_ROWS)
                    rows_reg = int'(cfg_data[ROWS_CFG_W-1:0]);
                else if (cfg_index == REG_IMAGE_COLS)
                    cols_reg = int'(cfg_data[COLS_CFG_W-1:0]);
            end
            if (s_valid && s_ready) begin
                roberts_advance(s_pixel);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_pixel <= pixel_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin : receiver
        gradient_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (gradient_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word row %0d col %0d",
                                            m_out_row, m_out_col));
                end else begin
                    want = gradient_words.pop_front();
                    if (m_out_row !== want.row)
                        flag_mismatch($sformatf("row got %0d want %0d", m_out_row, want.row));
                    if (m_out_col !== want.col)
                        flag_mismatch($sformatf("col got %0d want %0d", m_out_col, want.col));
                    if (m_magnitude !== want.mag)
                        flag_mismatch($sformatf("magnitude at (%0d,%0d) got %0d want %0d",
                                                want.row, want.col, m_magnitude, want.mag));
                    if (m_frame_end !== want.fin)
                        flag_mismatch($sformatf("frame_end at (%0d,%0d) got %b want %b",
                                                want.row, want.col, m_frame_end, want.fin));
                end
            end
            if (hold_served != hold_asks) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_pixel(input logic [PIX_W-1:0] px);
        pixel_backlog.push_back(px);
        items_queued++;
    endtask

    // every word accepted and every result back
    task automatic settle();
        while (items_taken != items_queued || gradient_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready))
            @(posedge aclk);
    endtask

    task automatic set_size(input int rows_val, input int cols_val);
        write_reg(REG_IMAGE_ROWS, rows_val);
        write_reg(REG_IMAGE_COLS, cols_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int rows_val, input int cols_val, input int count,
                             input pixel_style_t style);
        int               cols_eff;
        int               room;
        int               n;
        int               base;
        logic [PIX_W-1:0] px;
        cols_eff = clamp_count(cols_val & 'h7FF, MAX_COLS);
        n = count;
        // below row zero, only line-store columns already written may be read
        if (row_pos != 0 && cols_eff > line_fill) begin
            room = line_fill - 1 - col_pos;
            if (room >= 1)
                n = (n < room) ? n : room;
            else
                cols_val = $urandom_range(line_fill, 1);
        end
        set_size(rows_val, cols_val);
        base = $urandom_range(248);
        for (int k = 0; k < n; k++) begin
            case (style)
                PX_NOISE:  px = PIX_W'($urandom_range(255));
                PX_BINARY: px = $urandom_range(1) ? 8'hFF : 8'h00;
                PX_FLAT:   px = PIX_W'(base + $urandom_range(7));
                default:   px = k[0] ? 8'hFF : 8'h00;
            endcase
            queue_pixel(px);
        end
        settle();
    endtask

    initial begin : stimulus
        int           phase_no;
        int           pick;
        int           rows_val;
        int           cols_val;
        int           count;
        pixel_style_t style;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sizes out of reset: row-zero words report row 479
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        queue_pixel(8'd128);
        settle();
        // column counter already past the new last column, then three
        // rows of vertical stripes for saturated gradients
        set_size(2, 3);
        queue_pixel(8'd0);
        for (int k = 0; k < 9; k++)
            queue_pixel((k % 3 == 1) ? 8'h00 : 8'hFF);
        settle();
        // zero sizes count as one: every word ends a frame
        set_size(0, 0);
        queue_pixel(8'd17);
        queue_pixel(8'd200);
        settle();
        // oversized values clamp to the maximum
        set_size(8191, 2047);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        settle();
        set_size(MAX_ROWS, MAX_COLS);
        queue_pixel(8'd255);
        settle();
        set_size(3, 2);
        queue_pixel(8'd255);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        settle();
        // row counter past the new last row
        set_size(2, 2);
        queue_pixel(8'd0);
        queue_pixel(8'd255);
        settle();

        phase_no = 0;
        while (items_queued < 1900) begin
            pick = $urandom_range(99);
            if (pick < 70)
                rows_val = $urandom_range(6, 1);
            else if (pick < 78)
                rows_val = 0;
            else if (pick < 82)
                rows_val = MAX_ROWS;
            else if (pick < 86)
                rows_val = 8191;
            else
                rows_val = $urandom_range(8191);
            pick = $urandom_range(99);
            if (pick < 65)
                cols_val = $urandom_range(10, 1);
            else if (pick < 73)
                cols_val = 0;
            else if (pick < 81)
                cols_val = MAX_COLS;
            else if (pick < 86)
                cols_val = 2047;
            else if (pick < 92)
                cols_val = $urandom_range(8191);
            else
                cols_val = $urandom_range(64, 11);
            if (clamp_count(cols_val & 'h7FF, MAX_COLS) > 64)
                count = $urandom_range(60, 10);
            else
                count = $urandom_range(120, 20);
            style = pixel_style_t'($urandom_range(3));

            calm = 1'b0;
            // special phases keep their width inside the written line store
            if (phase_no == 5) begin
                // stretch with no idling on either side
                calm = 1'b1;
                rows_val = 4;
                cols_val = (row_pos != 0 && line_fill < 9) ? line_fill : 9;
                count = 260;
            end else if (phase_no == 9) begin
                // receiver holds off long enough to back up the input
                hold_asks++;
                rows_val = 5;
                cols_val = (row_pos != 0 && line_fill < 8) ? line_fill : 8;
                count = 150;
            end
            run_phase(rows_val, cols_val, count, style);
            phase_no++;
        end
        calm = 1'b0;

        settle();
        repeat (30) @(posedge aclk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/rcm_pkg.sv
rtl/rcm_ram.sv
rtl/rcm_front.sv
rtl/rcm_fifo.sv
rtl/rcm_back.sv
rtl/roberts_cross_magnitude.sv
tb/roberts_cross_magnitude_test.sv
